// ----- src/assert_macros.svh -----
// Assertion macros used by the top level of the packed pixel word decoder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define PPWD_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Checks that a condition never holds at a rising clock edge outside reset.
`define PPWD_NEVER(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ----- src/ppwd_pkg.sv -----
// Package with the constants, codes and color conversion functions of the decoder.
package ppwd_pkg;

    localparam int PALETTE_DEPTH = 4096;
    localparam int MAX_PIXELS    = 1048576;
    localparam int PAL_AW        = $clog2(PALETTE_DEPTH);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 21;
    localparam int PIX_CNT_W  = 21;

    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_MODE         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_SELECT     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_OFFSET     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLORS_PER_PALETTE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_COUNT        = 3'd4;

    localparam logic [1:0] MODE_4BPP  = 2'd0;
    localparam logic [1:0] MODE_8BPP  = 2'd1;
    localparam logic [1:0] MODE_16BPP = 2'd2;
    localparam logic [1:0] MODE_24BPP = 2'd3;

    localparam logic OP_PALETTE = 1'b0;
    localparam logic OP_IMAGE   = 1'b1;

    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_MID   = 2'd1;
    localparam logic [1:0] PH_END   = 2'd2;

    typedef logic [31:0] argb_t;

    // Rounded expansion of a five-bit channel to eight bits.
    localparam logic [7:0] WIDEN5 [32] = '{
        8'd0,   8'd8,   8'd16,  8'd25,  8'd33,  8'd41,  8'd49,  8'd58,
        8'd66,  8'd74,  8'd82,  8'd90,  8'd99,  8'd107, 8'd115, 8'd123,
        8'd132, 8'd140, 8'd148, 8'd156, 8'd165, 8'd173, 8'd181, 8'd189,
        8'd197, 8'd206, 8'd214, 8'd222, 8'd230, 8'd239, 8'd247, 8'd255
    };

    function automatic argb_t color16(input logic [15:0] c);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
        r = WIDEN5[c[4:0]];
        g = WIDEN5[c[9:5]];
        b = WIDEN5[c[14:10]];
        a = c[15] ? 8'd0 : 8'd255;
        if (c[14:0] == 15'd0)
        begin
            a = ~a;
        end
        return {a, r, g, b};
    endfunction

    function automatic argb_t color24(input logic [23:0] c);
        return {8'hff, c[7:0], c[15:8], c[23:16]};
    endfunction

endpackage

// ----- src/ppwd_ram.sv -----
// Generic single write port, single read port RAM with a registered read.
module ppwd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- src/packed_pixel_word_decoder.sv -----
// Top level of the packed pixel word decoder.
// Each accepted image word is held while its pixels are issued, one per clock while the output
// stage can take them, since the single read port of the palette RAM serves one lookup per
// cycle: a 4bpp word gives up to four pixels, an 8bpp word up to two, a 16bpp word one and a
// 24bpp word at most one. A palette write is done in a single issue step. The next word is
// taken in the cycle its predecessor issues its final pixel. An issued pixel passes through
// the lookup stage register and then the output register. Palette entries are undefined until
// written; there is no clearing pass after reset.
module packed_pixel_word_decoder (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [31:0]                    s_tdata,  // palette_addr[11:0], raw_word[27:12]
    input  logic                           s_tuser,  // op
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [31:0]                    m_tdata,  // pixel[31:0]
    output logic                           m_tlast,
    output logic                           m_tuser,  // range_error
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ppwd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ppwd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ppwd_pkg::*;

    `include "assert_macros.svh"

    logic [1:0]           pixel_mode_reg;
    logic [7:0]           palette_select_reg;
    logic signed [8:0]    palette_offset_reg;
    logic [8:0]           colors_per_palette_reg;
    logic [PIX_CNT_W-1:0] pixel_count_reg;

    logic                 cur_valid_reg;
    logic                 cur_valid_next;
    logic                 cur_op_reg;
    logic [11:0]          cur_addr_reg;
    logic [15:0]          cur_word_reg;
    logic [1:0]           cur_sub_reg;
    logic [1:0]           cur_sub_next;

    logic [PIX_CNT_W-1:0] emitted_reg;
    logic [PIX_CNT_W-1:0] emitted_next;
    logic [15:0]          carry_reg;
    logic [15:0]          carry_next;
    logic [1:0]           phase_reg;
    logic [1:0]           phase_next;

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic                 s1_lookup_reg;
    logic                 s1_err_reg;
    logic                 s1_last_reg;
    argb_t                s1_pix_reg;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    argb_t                out_pix_reg;
    logic                 out_last_reg;
    logic                 out_err_reg;

    logic                 s_fire;
    logic                 out_free;
    logic                 s1_adv;
    logic                 issue_ok;
    logic                 need_slot;
    logic                 go;
    logic                 issue_pix;
    logic                 cur_final;
    logic [2:0]           word_pixels;
    logic [7:0]           idx;
    logic signed [9:0]    entry;
    logic [16:0]          row_base;
    logic [17:0]          lut_addr;
    logic                 in_range;
    logic                 indexed;
    logic [31:0]          limit;
    logic                 pix_last;
    argb_t                direct_pix;
    argb_t                ram_rdata;
    logic                 ram_we;
    logic                 ram_re;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_mode_reg         <= MODE_4BPP;
            palette_select_reg     <= 8'd0;
            palette_offset_reg     <= 9'sd0;
            colors_per_palette_reg <= 9'd16;
            pixel_count_reg        <= 21'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PIXEL_MODE:         pixel_mode_reg         <= cfg_data[1:0];
                CFG_PALETTE_SELECT:     palette_select_reg     <= cfg_data[7:0];
                CFG_PALETTE_OFFSET:     palette_offset_reg     <= $signed(cfg_data[8:0]);
                CFG_COLORS_PER_PALETTE: colors_per_palette_reg <= cfg_data[8:0];
                CFG_PIXEL_COUNT:        pixel_count_reg        <= cfg_data[PIX_CNT_W-1:0];
                default:                ;
            endcase
        end
    end

    assign out_free = !out_valid_reg || m_tready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign issue_ok = !s1_valid_reg || out_free;

    always_comb
    begin
        case (pixel_mode_reg)
            MODE_4BPP:  word_pixels = 3'd4;
            MODE_8BPP:  word_pixels = 3'd2;
            MODE_16BPP: word_pixels = 3'd1;
            default:    word_pixels = (phase_reg == PH_START) ? 3'd0 : 3'd1;
        endcase
    end

    assign need_slot = (cur_op_reg == OP_IMAGE) && (word_pixels != 3'd0);
    assign go        = cur_valid_reg && (!need_slot || issue_ok);
    assign issue_pix = go && need_slot;
    assign indexed   = (pixel_mode_reg == MODE_4BPP) || (pixel_mode_reg == MODE_8BPP);

    always_comb
    begin
        if (pixel_mode_reg == MODE_4BPP)
        begin
            idx = {4'd0, cur_word_reg[{cur_sub_reg, 2'b00} +: 4]};
        end
        else
        begin
            idx = cur_word_reg[{cur_sub_reg[0], 3'b000} +: 8];
        end
    end

    assign entry    = {palette_offset_reg[8], palette_offset_reg} + $signed({2'b00, idx});
    assign row_base = palette_select_reg * colors_per_palette_reg;
    assign lut_addr = {1'b0, row_base} + {9'd0, entry[8:0]};
    assign in_range = !entry[9] && (entry[8:0] < colors_per_palette_reg)
                      && (32'(lut_addr) < 32'(PALETTE_DEPTH));

    always_comb
    begin
        case (pixel_mode_reg)
            MODE_16BPP: direct_pix = color16(cur_word_reg);
            MODE_24BPP:
            begin
                if (phase_reg == PH_MID)
                begin
                    direct_pix = color24({cur_word_reg[7:0], carry_reg});
                end
                else
                begin
                    direct_pix = color24({cur_word_reg, carry_reg[15:8]});
                end
            end
            default:    direct_pix = 32'd0;
        endcase
    end

    assign limit    = (32'(pixel_count_reg) < 32'(MAX_PIXELS)) ? 32'(pixel_count_reg)
                                                              : 32'(MAX_PIXELS);
    assign pix_last = (32'(emitted_reg) + 32'd1) >= limit;

    assign cur_final = (cur_op_reg == OP_PALETTE) || !need_slot || pix_last
                       || ({1'b0, cur_sub_reg} == (word_pixels - 3'd1));
    assign s_tready  = !cur_valid_reg || (go && cur_final);
    assign s_fire    = s_tvalid && s_tready;

    assign ram_we = go && (cur_op_reg == OP_PALETTE) && (32'(cur_addr_reg) < 32'(PALETTE_DEPTH));
    assign ram_re = issue_pix && indexed && in_range;

    ppwd_ram #(
        .WIDTH(32),
        .DEPTH(PALETTE_DEPTH)
    ) u_palette (
        .clk   (clk),
        .we    (ram_we),
        .waddr (PAL_AW'(cur_addr_reg)),
        .wdata (color16(cur_word_reg)),
        .re    (ram_re),
        .raddr (PAL_AW'(lut_addr)),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_sub_next   = cur_sub_reg;
        emitted_next   = emitted_reg;
        carry_next     = carry_reg;
        phase_next     = phase_reg;

        if (go)
        begin
            cur_sub_next = cur_sub_reg + 2'd1;
            if (cur_final)
            begin
                cur_valid_next = 1'b0;
            end
            if ((cur_op_reg == OP_IMAGE) && (pixel_mode_reg == MODE_24BPP))
            begin
                carry_next = cur_word_reg;
                case (phase_reg)
                    PH_START: phase_next = PH_MID;
                    PH_MID:   phase_next = PH_END;
                    default:  phase_next = PH_START;
                endcase
            end
        end
        if (issue_pix)
        begin
            if (pix_last)
            begin
                emitted_next = '0;
                phase_next   = PH_START;
            end
            else
            begin
                emitted_next = emitted_reg + 21'd1;
            end
        end
        if (s_fire)
        begin
            cur_valid_next = 1'b1;
            cur_sub_next   = 2'd0;
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (issue_pix)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_adv)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            cur_sub_reg   <= 2'd0;
            emitted_reg   <= '0;
            carry_reg     <= 16'd0;
            phase_reg     <= PH_START;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            cur_sub_reg   <= cur_sub_next;
            emitted_reg   <= emitted_next;
            carry_reg     <= carry_next;
            phase_reg     <= phase_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            cur_op_reg   <= s_tuser;
            cur_addr_reg <= s_tdata[11:0];
            cur_word_reg <= s_tdata[27:12];
        end
        if (issue_pix)
        begin
            s1_lookup_reg <= indexed && in_range;
            s1_err_reg    <= indexed && !in_range;
            s1_last_reg   <= pix_last;
            s1_pix_reg    <= indexed ? 32'd0 : direct_pix;
        end
        if (s1_adv)
        begin
            out_pix_reg  <= s1_lookup_reg ? ram_rdata : s1_pix_reg;
            out_last_reg <= s1_last_reg;
            out_err_reg  <= s1_err_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_pix_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_err_reg;

    `PPWD_ASSERT(a_read_lands_in_s1, ram_re |=> (s1_valid_reg && s1_lookup_reg),
        "palette read did not land in the lookup stage")
    `PPWD_ASSERT(a_last_clears_count, (issue_pix && pix_last) |=> (emitted_reg == '0),
        "pixel counter not cleared after the last pixel")
    `PPWD_ASSERT(a_error_pixel_zero, (m_tvalid && m_tuser) |-> (m_tdata == 32'd0),
        "out-of-range lookup gave a nonzero pixel")
    `PPWD_NEVER(a_phase_code, (phase_reg != PH_START) && (phase_reg != PH_MID)
        && (phase_reg != PH_END), "24bpp word phase out of range")
    `PPWD_ASSERT(a_write_single_cycle,
        (cur_valid_reg && (cur_op_reg == OP_PALETTE)) |-> (cur_sub_reg == 2'd0),
        "palette write held for more than one issue cycle")

endmodule

// ----- bench/tb_top.sv -----
// Self-checking testbench for the packed pixel word decoder, driven through its stream and config ports.
`timescale 1ns / 1ps

module tb_top;
    import ppwd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int REPORT_LINES = 50;
    localparam int DRAIN_LIMIT  = 5000;
    localparam int SETTLE       = 10;
    localparam int HOLD_CYCLES  = 80;
    localparam int PHASES       = 14;
    localparam int PHASE_ITEMS  = 11;

    typedef struct packed {
        argb_t pixel;
        logic  last;
        logic  range_err;
    } pixel_t;

    typedef enum logic [1:0] {ROW_CFG, ROW_PAL, ROW_IMG} row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [11:0]          addr;
        logic [20:0]          value;
        logic                 typed;
        pixel_t               px;
    } stim_row_t;

    localparam pixel_t NO_PIXEL = '0;

    localparam stim_row_t DIRECTED [41] = '{
        '{ROW_PAL, CFG_PIXEL_MODE, 12'd0, 21'h0000, 1'b0, NO_PIXEL},
        '{ROW_PAL, CFG_PIXEL_MODE, 12'd1, 21'hffff, 1'b0, NO_PIXEL},
        '{ROW_PAL, CFG_PIXEL_MODE, 12'd2, 21'h8000, 1'b0, NO_PIXEL},
        '{ROW_PAL, CFG_PIXEL_MODE, 12'd3, 21'h7fff, 1'b0, NO_PIXEL},
        '{ROW_PAL, CFG_PIXEL_MODE, 12'd4095, 21'h001f, 1'b0, NO_PIXEL},
        '{ROW_IMG, CFG_PIXEL_MODE, 12'd0, 21'h3210, 1'b1, '{32'h00000000, 1'b1, 1'b0}},
        '{ROW_CFG, CFG_PIXEL_COUNT, 12'd0, 21'd4, 1'b0, NO_PIXEL},
        '{ROW_IMG, CFG_PIXEL_MODE, 12'd0, 21'h0123, 1'b0, NO_PIXEL},
        '{ROW_CFG, CFG_PALETTE_OFFSET, 12'd0, 21'h1ff, 1'b0, NO_PIXEL},
        '{ROW_IMG, CFG_PIXEL_MODE, 12'd0, 21'h0000, 1'b0, NO_PIXEL},
        '{ROW_CFG, CFG_PALETTE_OFFSET, 12'd0, 21'h000, 1'b0, NO_PIXEL},
        '{ROW_CFG, CFG_PALETTE_SELECT, 12'd0, 21'd255, 1'b0, NO_PIXEL},
        '{ROW_CFG, CFG_PIXEL_COUNT, 12'd0, 21'd1, 1'b0, NO_PIXEL},
        '{ROW_IMG, CFG_PIXEL_MODE, 12'd0, 21'h000f, 1'b1, '{32'hffff0000, 1'b1, 1'b0}},
        '{ROW_CFG, CFG_COLORS_PER_PALETTE, 12'd0, 21'd256, 1'b0, NO_PIXEL},
        '{ROW_IMG, CFG_PIXEL_MODE, 12'd0, 21'h0000, 1'b1, '{32'h00000000, 1'b1, 1'b1}},
        '{ROW_CFG, CFG_PIXEL_MODE, 12'd0, 21'(MODE_8BPP), 1'b0, NO_PIXEL},
        '{ROW_CFG, CFG_PALETTE_SELECT, 12'd0, 21'd0, 1'b0, NO_PIXEL},
        '{ROW_CFG, CFG_PIXEL_COUNT, 12'd0, 21'd2, 1'b0, NO_PIXEL},
        '{ROW_IMG, CFG_PIXEL_MODE, 12'd0, 21'h0300, 1'b0, NO_PIXEL},
        '{ROW_CFG, CFG_PALETTE_OFFSET, 12'd0, 21'h0ff, 1'b0, NO_PIXEL},
        '{ROW_IMG, CFG_PIXEL_MODE, 12'd0, 21'hff01, 1'b0, NO_PIXEL},
        '{ROW_CFG, CFG_PALETTE_OFFSET, 12'd0, 21'h100, 1'b0, NO_PIXEL},
        '{ROW_CFG, CFG_COLORS_PER_PALETTE, 12'd0, 21'd511, 1'b0, NO_PIXEL},
        '{ROW_IMG, CFG_PIXEL_MODE, 12'd0, 21'hff00, 1'b0, NO_PIXEL},
        '{ROW_CFG, CFG_PIXEL_MODE, 12'd0, 21'(MODE_16BPP), 1'b0, NO_PIXEL},
        '{ROW_CFG, CFG_PIXEL_COUNT, 12'd0, 21'd0, 1'b0, NO_PIXEL},
        '{ROW_IMG, CFG_PIXEL_MODE, 12'd0, 21'h7fff, 1'b1, '{32'hffffffff, 1'b1, 1'b0}},
        '{ROW_IMG, CFG_PIXEL_MODE, 12'd0, 21'h8000, 1'b1, '{32'hff000000, 1'b1, 1'b0}},
        '{ROW_IMG, CFG_PIXEL_MODE, 12'd0, 21'h03e0, 1'b1, '{32'hff00ff00, 1'b1, 1'b0}},
        '{ROW_IMG, CFG_PIXEL_MODE, 12'd0, 21'hfc00, 1'b1, '{32'h000000ff, 1'b1, 1'b0}},
        '{ROW_CFG, CFG_PIXEL_MODE, 12'd0, 21'(MODE_24BPP), 1'b0, NO_PIXEL},
        '{ROW_CFG, CFG_PIXEL_COUNT, 12'd0, 21'd2, 1'b0, NO_PIXEL},
        '{ROW_IMG, CFG_PIXEL_MODE, 12'd0, 21'h2211, 1'b0, NO_PIXEL},
        '{ROW_IMG, CFG_PIXEL_MODE, 12'd0, 21'h4433, 1'b1, '{32'hff112233, 1'b0, 1'b0}},
        '{ROW_IMG, CFG_PIXEL_MODE, 12'd0, 21'h6655, 1'b1, '{32'hff445566, 1'b1, 1'b0}},
        '{ROW_CFG, CFG_PIXEL_COUNT, 12'd0, 21'h1fffff, 1'b0, NO_PIXEL},
        '{ROW_IMG, CFG_PIXEL_MODE, 12'd0, 21'hffff, 1'b0, NO_PIXEL},
        '{ROW_IMG, CFG_PIXEL_MODE, 12'd0, 21'h0000, 1'b0, NO_PIXEL},
        '{ROW_IMG, CFG_PIXEL_MODE, 12'd0, 21'hffff, 1'b0, NO_PIXEL},
        '{ROW_CFG, CFG_UNUSED, 12'd0, 21'h1fffff, 1'b0, NO_PIXEL}
    };

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [31:0]           s_tdata = '0;
    logic                  s_tuser = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [31:0]           m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    packed_pixel_word_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    argb_t             pal_mem [PALETTE_DEPTH];
    bit                pal_written [PALETTE_DEPTH];
    logic [20:0]       emitted = '0;
    logic [15:0]       carry = '0;
    logic [1:0]        phase = PH_START;
    logic [1:0]        mode = MODE_4BPP;
    logic [7:0]        sel = '0;
    logic signed [8:0] offs = '0;
    logic [8:0]        colors = 9'd16;
    logic [20:0]       pcount = 21'd1;

    pixel_t word_pixels [4];
    int     word_n;
    bit     image_done;
    pixel_t pending_pixels [$];

    bit calm = 1'b0;
    bit hold_request = 1'b0;
    int hold_left = 0;
    int mismatches = 0;
    int n_items = 0;
    int n_pal_writes = 0;
    int n_cfg = 0;
    int n_pixels = 0;
    int n_range = 0;
    int n_last = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [7:0] expand5(input logic [4:0] x);
        return 8'((32'(x) * 510 + 31) / 62);
    endfunction

    function automatic argb_t rgb555_to_argb(input logic [15:0] c);
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
        r = expand5(c[4:0]);
        g = expand5(c[9:5]);
        b = expand5(c[14:10]);
        a = c[15] ? 8'h00 : 8'hff;
        if (r == 8'h00 && g == 8'h00 && b == 8'h00)
        begin
            a = ~a;
        end
        return {a, r, g, b};
    endfunction

    function automatic argb_t rgb888_to_argb(input logic [23:0] c);
        return {8'hff, c[7:0], c[15:8], c[23:16]};
    endfunction

    function void emit_pixel(input argb_t px, input logic err);
        int   limit;
        logic last_flag;
        limit = (int'(pcount) < MAX_PIXELS) ? int'(pcount) : MAX_PIXELS;
        last_flag = (int'(emitted) + 1 >= limit);
        if (image_done || word_n >= 4)
        begin
            return;
        end
        word_pixels[word_n] = '{pixel: px, last: last_flag, range_err: err};
        word_n++;
        if (last_flag)
        begin
            emitted = '0;
            phase = PH_START;
            image_done = 1'b1;
        end
        else
        begin
            emitted = emitted + 21'd1;
        end
    endfunction

    // Palette address of an index, or -1 when the lookup falls outside the selected palette or the RAM.
    function int palette_slot(input logic [7:0] idx);
        int entry;
        int slot;
        entry = int'(offs) + int'(idx);
        if (entry < 0 || entry >= int'(colors))
        begin
            return -1;
        end
        slot = int'(sel) * int'(colors) + entry;
        return (slot >= PALETTE_DEPTH) ? -1 : slot;
    endfunction

    function void lookup_pixel(input logic [7:0] idx);
        int slot;
        slot = palette_slot(idx);
        if (slot < 0)
        begin
            emit_pixel('0, 1'b1);
        end
        else
        begin
            emit_pixel(pal_mem[slot], 1'b0);
        end
    endfunction

    function void decode_word(input logic op, input logic [11:0] addr, input logic [15:0] w);
        word_n = 0;
        image_done = 1'b0;
        if (op == OP_PALETTE)
        begin
            pal_mem[addr] = rgb555_to_argb(w);
            pal_written[addr] = 1'b1;
            return;
        end
        case (mode)
            MODE_4BPP:
            begin
                for (int k = 0; k < 4; k++)
                begin
                    lookup_pixel(8'(w[4*k +: 4]));
                end
            end
            MODE_8BPP:
            begin
                lookup_pixel(w[7:0]);
                lookup_pixel(w[15:8]);
            end
            MODE_16BPP:
            begin
                emit_pixel(rgb555_to_argb(w), 1'b0);
            end
            default:
            begin
                if (phase == PH_MID)
                begin
                    phase = PH_END;
                    emit_pixel(rgb888_to_argb({w[7:0], carry}), 1'b0);
                    carry = w;
                end
                else if (phase == PH_END)
                begin
                    phase = PH_START;
                    emit_pixel(rgb888_to_argb({w, carry[15:8]}), 1'b0);
                    carry = w;
                end
                else
                begin
                    carry = w;
                    phase = PH_MID;
                end
            end
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < REPORT_LINES)
        begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
        mismatches++;
    endtask

    task automatic send_item(input logic op, input logic [11:0] addr, input logic [15:0] w,
                             input bit typed, input pixel_t typed_px);
        if (!calm)
        begin
            while ($urandom_range(99) < 28)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0, w, addr};
        do @(posedge clk); while (!s_tready);
        decode_word(op, addr, w);
        n_items++;
        if (op == OP_PALETTE)
        begin
            n_pal_writes++;
        end
        if (typed)
        begin
            pending_pixels.insert(pending_pixels.size(), typed_px);
        end
        else
        begin
            for (int k = 0; k < word_n; k++)
            begin
                pending_pixels.insert(pending_pixels.size(), word_pixels[k]);
            end
        end
    endtask

    // Entries that an indexed word will read are written first, so no unwritten entry is read.
    task automatic send_image(input logic [15:0] w, input bit typed, input pixel_t typed_px);
        int lanes;
        int bits;
        int slot;
        lanes = (mode == MODE_4BPP) ? 4 : 2;
        bits  = (mode == MODE_4BPP) ? 4 : 8;
        if (mode == MODE_4BPP || mode == MODE_8BPP)
        begin
            for (int k = 0; k < lanes; k++)
            begin
                slot = palette_slot(8'((w >> (k * bits)) & ((1 << bits) - 1)));
                if (slot >= 0 && !pal_written[slot])
                begin
                    send_item(OP_PALETTE, 12'(slot), 16'($urandom_range(65535)), 1'b0, NO_PIXEL);
                end
            end
        end
        send_item(OP_IMAGE, 12'd0, w, typed, typed_px);
    endtask

    task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input logic [20:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
        n_cfg++;
        case (idx)
            CFG_PIXEL_MODE:         mode = value[1:0];
            CFG_PALETTE_SELECT:     sel = value[7:0];
            CFG_PALETTE_OFFSET:     offs = value[8:0];
            CFG_COLORS_PER_PALETTE: colors = value[8:0];
            CFG_PIXEL_COUNT:        pcount = value;
            default:                ;
        endcase
    endtask

    task automatic wait_for_idle();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE) @(posedge clk);
        if (pending_pixels.size() != 0)
        begin
            report_mismatch($sformatf("%0d expected pixels never arrived",
                                      pending_pixels.size()));
            pending_pixels.delete();
        end
    endtask

    initial
    begin
        pixel_t got;
        pixel_t want;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                got = '{pixel: m_tdata, last: m_tlast, range_err: m_tuser};
                n_pixels++;
                n_range += got.range_err;
                n_last += got.last;
                if (pending_pixels.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected pixel %h last %b range %b",
                                              got.pixel, got.last, got.range_err));
                end
                else
                begin
                    want = pending_pixels.pop_front();
                    if (got.pixel !== want.pixel || got.last !== want.last
                        || got.range_err !== want.range_err)
                    begin
                        report_mismatch($sformatf(
                            "pixel %0d got %h/%b/%b, expected %h/%b/%b (pixel/last/range)",
                            n_pixels, got.pixel, got.last, got.range_err,
                            want.pixel, want.last, want.range_err));
                    end
                end
            end
        end
    end

    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= calm || ($urandom_range(99) >= 28);
            end
        end
    end

    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        stim_row_t   row;
        int          r;
        int          span;
        logic [1:0]  mode_v;
        logic [20:0] sel_v;
        logic [20:0] offs_v;
        logic [20:0] colors_v;
        logic [20:0] count_v;
        logic [15:0] w;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
        begin
            row = DIRECTED[i];
            case (row.kind)
                ROW_CFG:
                begin
                    wait_for_idle();
                    set_register(row.reg_idx, row.value);
                end
                ROW_PAL:  send_item(OP_PALETTE, row.addr, row.value[15:0], 1'b0, NO_PIXEL);
                default:  send_image(row.value[15:0], row.typed, row.px);
            endcase
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            wait_for_idle();
            calm = (ph == 6 || ph == 7);
            mode_v = 2'($urandom_range(3));
            r = $urandom_range(99);
            colors_v = (r < 40) ? 21'd16 : (r < 65) ? 21'd256 :
                       (r < 90) ? 21'($urandom_range(1, 64)) :
                       ($urandom_range(1) ? 21'd511 : 21'd0);
            span = (colors_v == 0) ? 256 : PALETTE_DEPTH / int'(colors_v);
            sel_v = ($urandom_range(99) < 80) ? 21'($urandom_range((span > 256) ? 255 : span - 1))
                                              : 21'($urandom_range(255));
            r = $urandom_range(99);
            offs_v = (r < 60) ? 21'd0 : (r < 85) ? 21'(9'($urandom_range(30) - 15))
                                                 : 21'($urandom_range(511));
            r = $urandom_range(99);
            count_v = (r < 70) ? 21'($urandom_range(1, 12)) : (r < 80) ? 21'd0 :
                      (r < 90) ? 21'(MAX_PIXELS - 1 + $urandom_range(1) * 1048576)
                               : 21'($urandom_range(2097151));
            if (ph == 2)
            begin
                mode_v = MODE_4BPP;
                sel_v = '0;
                offs_v = '0;
                colors_v = 21'd16;
                count_v = 21'h1fffff;
            end
            set_register(CFG_PIXEL_MODE, 21'(mode_v));
            set_register(CFG_PALETTE_SELECT, sel_v);
            set_register(CFG_PALETTE_OFFSET, offs_v);
            set_register(CFG_COLORS_PER_PALETTE, colors_v);
            set_register(CFG_PIXEL_COUNT, count_v);
            if (ph == 2)
            begin
                hold_request = 1'b1;
            end
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                r = $urandom_range(99);
                if (r < 15)
                begin
                    send_item(OP_PALETTE, 12'($urandom_range(4095)),
                              16'($urandom_range(65535)), 1'b0, NO_PIXEL);
                end
                else
                begin
                    w = (r < 20) ? 16'h0000 : (r < 25) ? 16'hffff : 16'($urandom_range(65535));
                    send_image(w, 1'b0, NO_PIXEL);
                end
            end
        end

        wait_for_idle();
        $display("Run covered %0d input transactions (%0d palette writes) and %0d register writes.",
                 n_items, n_pal_writes, n_cfg);
        $display("Checked %0d pixels in all four modes: %0d out-of-range lookups, %0d image ends.",
                 n_pixels, n_range, n_last);
        if (mismatches == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
